// File: hw/rtl/rcpwm_pkg.sv
// Shared types and constants for the RC pulse width monitor.
// Used by rcpwm_meas, rcpwm_rsp_buf and rc_pulse_width_monitor; no dependencies.
`default_nettype none

package rcpwm_pkg;

   localparam int TIMER_BITS = 16;
   localparam int WIDTH_BITS = 16;
   localparam int COUNT_BITS = 8;
   localparam int SCALE_BITS = 8;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [WIDTH_BITS-1:0] MIN_WIDTH_RESET = 16'd1000;
   localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_RESET = 16'd2000;
   localparam logic [COUNT_BITS-1:0] MIN_PULSES_RESET = 8'd10;
   localparam logic [SCALE_BITS-1:0] US_PER_TICK_RESET = 8'd4;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_WIDTH   = 2'd0,
      CSR_MAX_WIDTH   = 2'd1,
      CSR_MIN_PULSES  = 2'd2,
      CSR_US_PER_TICK = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0] min_width_us;
      logic [WIDTH_BITS-1:0] max_width_us;
      logic [COUNT_BITS-1:0] min_pulses;
      logic [SCALE_BITS-1:0] us_per_tick;
   } cfg_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0] pulse_width_us;
      logic                  channel_good;
      logic                  new_pulse;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/rcpwm_meas.sv
// Measurement state and per-sample update: tick counter, edge tracking,
// width scaling and bounds check, good-pulse count per wrap. Uses rcpwm_pkg.
`default_nettype none

module rcpwm_meas (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rcpwm_pkg::cfg_type   cfg,
   input  wire logic                 sample_xfer,
   input  wire logic                 pin_level,
   output rcpwm_pkg::result_type     result
);

   logic [rcpwm_pkg::TIMER_BITS-1:0] tick_ff, tick_in;
   logic [rcpwm_pkg::TIMER_BITS-1:0] start_ff, start_in;
   logic                             prev_ff, prev_in;
   logic                             await_fall_ff, await_fall_in;
   logic [rcpwm_pkg::COUNT_BITS-1:0] pulses_ff, pulses_in;
   logic [rcpwm_pkg::WIDTH_BITS-1:0] width_ff, width_in;
   logic                             good_ff, good_in;

   logic [rcpwm_pkg::TIMER_BITS-1:0] elapsed;
   logic [rcpwm_pkg::TIMER_BITS+rcpwm_pkg::SCALE_BITS-1:0] product;
   logic [rcpwm_pkg::WIDTH_BITS-1:0] width;
   logic                             in_bounds;
   logic                             fresh;
   logic [rcpwm_pkg::COUNT_BITS-1:0] pulses_edge;
   logic                             await_edge;

   assign elapsed   = tick_ff - start_ff;
   assign product   = elapsed * {{rcpwm_pkg::TIMER_BITS{1'b0}}, cfg.us_per_tick};
   assign width     = product[rcpwm_pkg::WIDTH_BITS-1:0];
   assign in_bounds = (width >= cfg.min_width_us) && (width <= cfg.max_width_us);

   always_comb begin
      start_in    = start_ff;
      await_edge  = await_fall_ff;
      width_in    = width_ff;
      pulses_edge = pulses_ff;
      fresh       = 1'b0;
      good_in     = good_ff;

      if (!await_fall_ff) begin
         if (!prev_ff && pin_level) begin
            start_in   = tick_ff;
            await_edge = 1'b1;
         end
      end else if (prev_ff && !pin_level) begin
         await_edge = 1'b0;
         if (in_bounds) begin
            width_in = width;
            fresh    = 1'b1;
            if (pulses_ff != rcpwm_pkg::COUNT_MAX) begin
               pulses_edge = pulses_ff + 1'b1;
            end
         end
      end

      prev_in       = pin_level;
      tick_in       = tick_ff + 1'b1;
      await_fall_in = await_edge;
      pulses_in     = pulses_edge;

      // counter wrap closes the period; edge results above already count
      if (tick_in == '0) begin
         if (pulses_edge < cfg.min_pulses) begin
            await_fall_in = 1'b0;
            good_in       = 1'b0;
         end else begin
            good_in = 1'b1;
         end
         pulses_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         start_ff      <= '0;
         prev_ff       <= 1'b1;
         await_fall_ff <= 1'b0;
         pulses_ff     <= '0;
         width_ff      <= '0;
         good_ff       <= 1'b0;
      end else if (sample_xfer) begin
         tick_ff       <= tick_in;
         start_ff      <= start_in;
         prev_ff       <= prev_in;
         await_fall_ff <= await_fall_in;
         pulses_ff     <= pulses_in;
         width_ff      <= width_in;
         good_ff       <= good_in;
      end
   end

   assign result.pulse_width_us = width_in;
   assign result.channel_good   = good_in;
   assign result.new_pulse      = fresh;

endmodule

`default_nettype wire

// File: hw/rtl/rcpwm_rsp_buf.sv
// Result register with a skid stage so the sample side can pass one more result
// while the receiver stalls. Uses rcpwm_pkg.
`default_nettype none

module rcpwm_rsp_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_xfer,
   input  wire rcpwm_pkg::result_type in_data,
   output logic                       in_stall,
   output logic                       out_valid,
   input  wire logic                  out_stall,
   output rcpwm_pkg::result_type      out_data
);

   logic                  main_valid_ff, main_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   rcpwm_pkg::result_type main_data_ff, main_data_in;
   rcpwm_pkg::result_type skid_data_ff, skid_data_in;
   logic                  main_free;

   assign main_free = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_xfer;
            main_data_in  = in_data;
         end
      end else if (in_xfer) begin
         // in_stall is skid_valid_ff, so the skid is empty here
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rc_pulse_width_monitor.sv
// Top level of the RC pulse width monitor: configuration registers, the
// measurement core and the result buffer. Uses rcpwm_pkg, rcpwm_meas, rcpwm_rsp_buf.
//
// Usage:
//   req_valid/req_pin_level carry one receiver pin sample per timer tick; a
//   sample transfers when req_valid is high and req_stall is low.
//   Every sample gives exactly one result on rsp_*: the last accepted pulse
//   width in microseconds, the channel-good flag of the last counter period
//   and new_pulse, set when an accepted pulse ended on that sample.
//   Throughput is one sample per cycle while req_stall is low; the edge, scale
//   and bounds logic is combinational between the state registers and the
//   result register.
//   When the receiver stalls, one more result is held in a skid stage and
//   req_stall rises only once that stage is full; nothing is dropped.
//   csr_write_en/csr_index/csr_wdata write min_width_us (0), max_width_us (1),
//   min_pulses (2) and us_per_tick (3); write only while the block is idle.
//   Synchronous reset restores 1000, 2000, 10, 4 in the registers, clears the
//   tick counter and pulse state, sets the previous pin level high and
//   empties the result buffer.
`default_nettype none

module rc_pulse_width_monitor (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_pin_level,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [rcpwm_pkg::WIDTH_BITS-1:0]          rsp_pulse_width_us,
   output logic                                      rsp_channel_good,
   output logic                                      rsp_new_pulse,
   input  wire logic                                 csr_write_en,
   input  wire logic [rcpwm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rcpwm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   rcpwm_pkg::cfg_type    cfg_ff, cfg_in;
   rcpwm_pkg::result_type meas_result;
   rcpwm_pkg::result_type rsp_data;
   logic                  req_xfer;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (rcpwm_pkg::csr_index_type'(csr_index))
            rcpwm_pkg::CSR_MIN_WIDTH:   cfg_in.min_width_us = csr_wdata;
            rcpwm_pkg::CSR_MAX_WIDTH:   cfg_in.max_width_us = csr_wdata;
            rcpwm_pkg::CSR_MIN_PULSES:
               cfg_in.min_pulses = csr_wdata[rcpwm_pkg::COUNT_BITS-1:0];
            rcpwm_pkg::CSR_US_PER_TICK:
               cfg_in.us_per_tick = csr_wdata[rcpwm_pkg::SCALE_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_width_us <= rcpwm_pkg::MIN_WIDTH_RESET;
         cfg_ff.max_width_us <= rcpwm_pkg::MAX_WIDTH_RESET;
         cfg_ff.min_pulses   <= rcpwm_pkg::MIN_PULSES_RESET;
         cfg_ff.us_per_tick  <= rcpwm_pkg::US_PER_TICK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_xfer = req_valid && !req_stall;

   rcpwm_meas u_meas (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .sample_xfer (req_xfer),
      .pin_level   (req_pin_level),
      .result      (meas_result)
   );

   rcpwm_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_xfer   (req_xfer),
      .in_data   (meas_result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_pulse_width_us = rsp_data.pulse_width_us;
   assign rsp_channel_good   = rsp_data.channel_good;
   assign rsp_new_pulse      = rsp_data.new_pulse;

endmodule

`default_nettype wire

// File: tb/rc_pulse_width_monitor_tb.sv
// Self-checking bench for rc_pulse_width_monitor: random pin pulse trains under several
// register settings, with a result predictor in a small scoreboard class. Needs rcpwm_pkg.
module rc_pulse_width_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rcpwm_pkg::*;

   // worst case is every transfer of the roughly 2000 samples behind the longest gap
   // and a long run of stalls
   localparam longint CYCLE_LIMIT = 1_000_000;

   class rc_channel_tracker;
      cfg_type               cfg;
      logic [TIMER_BITS-1:0] ticks;
      logic [TIMER_BITS-1:0] rise_ticks;
      logic                  last_level;
      logic                  armed;
      logic                  chan_good;
      logic [COUNT_BITS-1:0] pulse_tally;
      logic [WIDTH_BITS-1:0] held_width;
      result_type            predicted_readings[$];
      int                    errors;
      int                    readings;

      function new();
         cfg.min_width_us = MIN_WIDTH_RESET;
         cfg.max_width_us = MAX_WIDTH_RESET;
         cfg.min_pulses = MIN_PULSES_RESET;
         cfg.us_per_tick = US_PER_TICK_RESET;
         ticks = '0;
         rise_ticks = '0;
         last_level = 1'b1;
         armed = 1'b0;
         chan_good = 1'b0;
         pulse_tally = '0;
         held_width = '0;
         errors = 0;
         readings = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_MIN_WIDTH:   cfg.min_width_us = value[WIDTH_BITS-1:0];
            CSR_MAX_WIDTH:   cfg.max_width_us = value[WIDTH_BITS-1:0];
            CSR_MIN_PULSES:  cfg.min_pulses = value[COUNT_BITS-1:0];
            CSR_US_PER_TICK: cfg.us_per_tick = value[SCALE_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void take_sample(logic level);
         logic [TIMER_BITS-1:0]            span;
         logic [TIMER_BITS+SCALE_BITS-1:0] scaled;
         logic [WIDTH_BITS-1:0]            width;
         logic                             fresh;
         fresh = 1'b0;
         if (!armed) begin
            if (!last_level && level) begin
               rise_ticks = ticks;
               armed = 1'b1;
            end
         end else if (last_level && !level) begin
            span = ticks - rise_ticks;
            scaled = span * cfg.us_per_tick;
            width = scaled[WIDTH_BITS-1:0];
            armed = 1'b0;
            if (width >= cfg.min_width_us && width <= cfg.max_width_us) begin
               held_width = width;
               if (pulse_tally != COUNT_MAX)
                  pulse_tally++;
               fresh = 1'b1;
            end
         end
         last_level = level;
         // wrap check runs after edge handling in the same tick
         ticks++;
         if (ticks == '0) begin
            if (pulse_tally < cfg.min_pulses) begin
               armed = 1'b0;
               chan_good = 1'b0;
            end else begin
               chan_good = 1'b1;
            end
            pulse_tally = '0;
         end
         predicted_readings.push_back({held_width, chan_good, fresh});
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10)
            $display("%s", msg);
      endfunction

      function void check_reading(result_type got);
         result_type want;
         readings++;
         if (predicted_readings.size() == 0) begin
            note_error($sformatf("result %0d arrived with nothing expected", readings));
            return;
         end
         want = predicted_readings.pop_front();
         if (got.pulse_width_us !== want.pulse_width_us)
            note_error($sformatf("result %0d pulse_width_us: expected %0d got %0d",
                                 readings, want.pulse_width_us, got.pulse_width_us));
         if (got.channel_good !== want.channel_good)
            note_error($sformatf("result %0d channel_good: expected %0b got %0b",
                                 readings, want.channel_good, got.channel_good));
         if (got.new_pulse !== want.new_pulse)
            note_error($sformatf("result %0d new_pulse: expected %0b got %0b",
                                 readings, want.new_pulse, got.new_pulse));
      endfunction

      function int pending();
         return predicted_readings.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_pin_level = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [WIDTH_BITS-1:0]    rsp_pulse_width_us;
   logic                     rsp_channel_good;
   logic                     rsp_new_pulse;
   logic                     csr_write_en = 1'b0;
   csr_index_type            csr_index = CSR_MIN_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   rc_channel_tracker tracker;
   int                samples_sent = 0;
   int                send_quiet = 0;
   int                stall_quiet = 0;
   int                stall_hold = 0;
   longint            cycles = 0;

   rc_pulse_width_monitor u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pin_level      (req_pin_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pulse_width_us (rsp_pulse_width_us),
      .rsp_channel_good   (rsp_channel_good),
      .rsp_new_pulse      (rsp_new_pulse),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   // mostly no idling, some short gaps, a few long ones, now and then a quiet stretch
   function automatic int idle_cycles(inout int quiet_left);
      int roll;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      roll = $urandom_range(999, 0);
      if (roll < 3) begin
         quiet_left = $urandom_range(3000, 300);
         return 0;
      end
      if (roll < 90)
         return $urandom_range(3, 1);
      if (roll < 96)
         return $urandom_range(16, 8);
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold--;
         rsp_stall <= 1'b1;
      end else begin
         stall_hold = idle_cycles(stall_quiet);
         rsp_stall <= (stall_hold > 0);
         if (stall_hold > 0)
            stall_hold--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_reading({rsp_pulse_width_us, rsp_channel_good, rsp_new_pulse});
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_sample(input logic level);
      int gap;
      gap = idle_cycles(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pin_level <= level;
      do @(posedge clock); while (req_stall);
      tracker.take_sample(level);
      samples_sent++;
   endtask

   task automatic send_pattern(input string bits);
      for (int i = 0; i < bits.len(); i++)
         send_sample(bits[i] == "1");
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   // junk in the upper byte of the 8-bit registers must be dropped
   task automatic write_config(input logic [WIDTH_BITS-1:0] min_w, max_w,
                               input logic [COUNT_BITS-1:0] min_p,
                               input logic [SCALE_BITS-1:0] scale);
      wait_for_results();
      repeat (2) @(posedge clock);
      write_register(CSR_MIN_WIDTH, min_w);
      write_register(CSR_MAX_WIDTH, max_w);
      write_register(CSR_MIN_PULSES, {8'($urandom), min_p});
      write_register(CSR_US_PER_TICK, {8'($urandom), scale});
      csr_write_en <= 1'b0;
   endtask

   // pulse trains: mostly in-window highs, some at the window edges, some off-window
   // and some pin noise
   task automatic run_pulses(input int stop_at, input int lo_min, lo_max,
                             input int hi_min, hi_max);
      int pick;
      int lo;
      int hi;
      while (samples_sent < stop_at) begin
         pick = $urandom_range(99, 0);
         if (pick < 10) begin
            repeat ($urandom_range(16, 1)) send_sample(1'($urandom_range(1, 0)));
         end else begin
            lo = $urandom_range(lo_max, lo_min);
            if (pick < 75) begin
               hi = $urandom_range(hi_max, hi_min);
            end else if (pick < 90) begin
               case ($urandom_range(3, 0))
                  0: hi = hi_min - 1;
                  1: hi = hi_min;
                  2: hi = hi_max;
                  default: hi = hi_max + 1;
               endcase
            end else begin
               hi = $urandom_range(2 * hi_max, 1);
            end
            repeat (lo) send_sample(1'b0);
            repeat (hi) send_sample(1'b1);
         end
      end
   endtask

   initial begin
      int e_min;
      int e_max;
      int e_scale;
      int e_hi_min;
      int e_hi_max;
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: falling edge before arming is ignored, short pulse rejected
      send_pattern("10100110");
      // zero scale: every width is 0, accepted with a zero lower bound
      write_config(16'd0, 16'hFFFF, 8'd0, 8'd0);
      send_pattern("0101110");
      // lower bound equal to upper bound, then crossed bounds
      write_config(16'd3, 16'd3, 8'd10, 8'd1);
      send_pattern("01110110111110");
      write_config(16'd5, 16'd3, 8'd10, 8'd1);
      send_pattern("0111110");

      // reset window with a coarse tick so pulses stay short
      write_config(MIN_WIDTH_RESET, MAX_WIDTH_RESET, MIN_PULSES_RESET, 8'd100);
      run_pulses(500, 2, 20, 10, 20);
      wait_for_results();
      run_pulses(800, 2, 20, 10, 20);

      // products past 16 bits fold back into a narrow window
      write_config(16'd0, 16'd5000, 8'd255, 8'd255);
      run_pulses(1300, 1, 20, 250, 280);

      // only 257 ticks at 255 us lands exactly on the top width
      write_config(16'hFFFF, 16'hFFFF, 8'd0, 8'd255);
      run_pulses(1600, 1, 20, 257, 257);

      e_min = $urandom_range(3000, 0);
      e_max = e_min + $urandom_range(3000, 0);
      e_scale = $urandom_range(255, 50);
      e_hi_min = (e_min + e_scale - 1) / e_scale;
      if (e_hi_min < 1)
         e_hi_min = 1;
      e_hi_max = e_max / e_scale;
      if (e_hi_max < e_hi_min)
         e_hi_max = e_hi_min;
      if (e_hi_max > 80)
         e_hi_max = 80;
      write_config(16'(e_min), 16'(e_max), 8'($urandom_range(255, 0)), 8'(e_scale));
      run_pulses(samples_sent + 400, 1, 30, e_hi_min, e_hi_max);

      wait_for_results();
      repeat (4) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
